// ===== hw/rtl/spg_pkg.sv =====
// Shared types and constants of the setpoint profile generator.
// No dependencies; imported by every module of the block.
package spg_pkg;

    localparam int ADDR_W      = 5;
    localparam int QUO_W       = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;
    localparam int CW          = 34;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_BASE   = 3'd1;
    localparam logic [2:0] REG_SECOND = 3'd2;
    localparam logic [2:0] REG_START  = 3'd3;
    localparam logic [2:0] REG_DUR    = 3'd4;
    localparam logic [2:0] REG_FREQ   = 3'd5;
    localparam logic [2:0] REG_PHASE  = 3'd6;

    localparam logic [1:0] KIND_CONST = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_RAMP  = 2'd2;
    localparam logic [1:0] KIND_SINE  = 2'd3;

    localparam logic [1:0] SEL_BASE   = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_RAMP   = 2'd2;
    localparam logic [1:0] SEL_SINE   = 2'd3;

    localparam logic signed [CW-1:0] CORDIC_ONE = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] base;
        logic signed [23:0] second;
        logic [31:0]        start;
        logic [31:0]        dur;
        logic [31:0]        freq;
        logic [15:0]        phase;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  sel;
        logic [31:0] d;
    } q_entry_t;

    typedef struct packed {
        logic [1:0]           sel;
        logic                 neg;
        logic [31:0]          rem;
        logic [QUO_W-1:0]     nl;
        logic [QUO_W-1:0]     quo;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } stage_t;

endpackage

// ===== hw/rtl/spg_cfg.sv =====
// APB register file of the setpoint profile generator.
// Depends on spg_pkg for the register map and cfg_t.
module spg_cfg import spg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);
    cfg_t cfg_reg;
    logic wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kind   <= KIND_CONST;
            cfg_reg.base   <= '0;
            cfg_reg.second <= '0;
            cfg_reg.start  <= '0;
            cfg_reg.dur    <= 32'd65536;
            cfg_reg.freq   <= '0;
            cfg_reg.phase  <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_KIND:   cfg_reg.kind   <= pwdata[1:0];
                REG_BASE:   cfg_reg.base   <= pwdata[23:0];
                REG_SECOND: cfg_reg.second <= pwdata[23:0];
                REG_START:  cfg_reg.start  <= pwdata;
                REG_DUR:    cfg_reg.dur    <= pwdata;
                REG_FREQ:   cfg_reg.freq   <= pwdata;
                REG_PHASE:  cfg_reg.phase  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_KIND:   prdata = {30'b0, cfg_reg.kind};
            REG_BASE:   prdata = {8'b0, cfg_reg.base};
            REG_SECOND: prdata = {8'b0, cfg_reg.second};
            REG_START:  prdata = cfg_reg.start;
            REG_DUR:    prdata = cfg_reg.dur;
            REG_FREQ:   prdata = cfg_reg.freq;
            REG_PHASE:  prdata = {16'b0, cfg_reg.phase};
            default:    prdata = '0;
        endcase
    end

    a_kind_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && idx == REG_KIND) |=> (cfg_reg.kind == $past(pwdata[1:0])))
        else $error("profile kind write lost");

endmodule

// ===== hw/rtl/spg_queue.sv =====
// Short request queue between the front and back parts.
// Depends on spg_pkg for q_entry_t and the queue depth.
module spg_queue import spg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     valid,
    output q_entry_t head
);
    q_entry_t mem_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("queue pop while empty");

endmodule

// ===== hw/rtl/spg_front.sv =====
// Front part: accepts sample times, classifies them against the profile.
// Depends on spg_pkg and spg_queue.
module spg_front import spg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample_time,
    input  logic        q_pop,
    output logic        q_valid,
    output q_entry_t    q_head
);
    q_entry_t entry;
    logic full, push, ge, gt;
    logic [31:0] d;

    assign ge      = s_sample_time >= cfg.start;
    assign gt      = s_sample_time > cfg.start;
    assign d       = s_sample_time - cfg.start;
    assign s_ready = !full;
    assign push    = s_valid && s_ready;

    always_comb begin
        entry.d = d;
        unique case (cfg.kind)
            KIND_CONST: entry.sel = SEL_BASE;
            KIND_STEP:  entry.sel = ge ? SEL_SECOND : SEL_BASE;
            KIND_RAMP: begin
                if (!gt)
                    entry.sel = SEL_BASE;
                else if (cfg.dur == '0 || d >= cfg.dur)
                    entry.sel = SEL_SECOND;
                else
                    entry.sel = SEL_RAMP;
            end
            KIND_SINE:  entry.sel = ge ? SEL_SINE : SEL_BASE;
            default:    entry.sel = SEL_BASE;
        endcase
    end

    spg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (entry),
        .full       (full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

endmodule

// ===== hw/rtl/spg_back.sv =====
// Back part: ramp divider and sine CORDIC pipeline, output register.
// Depends on spg_pkg.
module spg_back import spg_pkg::*; #(
    parameter int SINE_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  q_entry_t           q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_setpoint
);
    localparam int LOOP = (QUO_W > SINE_STAGES + 1) ? QUO_W : SINE_STAGES + 1;

    logic en;
    logic [LOOP:0] vld_reg;
    stage_t st_reg  [0:LOOP];
    stage_t st_next [0:LOOP];
    logic f_vld_reg, m_valid_reg;
    logic [1:0] f_sel_reg;
    logic signed [57:0] f_prod_reg;
    logic signed [24:0] f_q_reg;
    logic signed [23:0] m_setpoint_reg;

    logic signed [24:0] diff;
    logic [24:0] absd;
    logic [55:0] prod_r;
    logic [63:0] prod_s;

    assign en         = !m_valid_reg || m_ready;
    assign q_pop      = en && q_valid;
    assign m_valid    = m_valid_reg;
    assign m_setpoint = m_setpoint_reg;

    assign diff   = {cfg.second[23], cfg.second} - {cfg.base[23], cfg.base};
    assign absd   = diff[24] ? -diff : diff;
    assign prod_r = 56'(q_head.d) * 56'(absd[QUO_W-1:0]);
    assign prod_s = 64'(cfg.freq) * 64'(q_head.d);

    always_comb begin
        st_next[0].sel = q_head.sel;
        st_next[0].neg = diff[24];
        st_next[0].rem = prod_r[55:QUO_W];
        st_next[0].nl  = prod_r[QUO_W-1:0];
        st_next[0].quo = '0;
        st_next[0].x   = '0;
        st_next[0].y   = '0;
        st_next[0].z   = {2'b0, prod_s[39:8] + {cfg.phase, 16'h0000}};
    end

    for (genvar k = 0; k < LOOP; k++) begin : g_stage
        localparam int SH = (k >= 1) ? k - 1 : 0;
        always_comb begin
            stage_t s;
            stage_t n;
            logic [32:0] r2;
            logic [31:0] a;
            s  = st_reg[k];
            n  = s;
            r2 = {s.rem, s.nl[QUO_W-1]};
            a  = s.z[31:0];
            if (k < QUO_W) begin
                n.nl = {s.nl[QUO_W-2:0], 1'b0};
                if (r2 >= {1'b0, cfg.dur}) begin
                    n.rem = 32'(r2 - {1'b0, cfg.dur});
                    n.quo = {s.quo[QUO_W-2:0], 1'b1};
                end else begin
                    n.rem = r2[31:0];
                    n.quo = {s.quo[QUO_W-2:0], 1'b0};
                end
            end
            if (k == 0) begin
                if (a[31:30] == 2'b01 || a[31:30] == 2'b10)
                    a = 32'h8000_0000 - a;
                n.x = CORDIC_ONE;
                n.y = '0;
                n.z = {{(CW-32){a[31]}}, a};
            end else if (k <= SINE_STAGES) begin
                if (!s.z[CW-1]) begin
                    n.x = s.x - (s.y >>> SH);
                    n.y = s.y + (s.x >>> SH);
                    n.z = s.z - $signed({{(CW-32){1'b0}}, ATAN_TURNS[SH]});
                end else begin
                    n.x = s.x + (s.y >>> SH);
                    n.y = s.y - (s.x >>> SH);
                    n.z = s.z + $signed({{(CW-32){1'b0}}, ATAN_TURNS[SH]});
                end
            end
            st_next[k+1] = n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            f_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LOOP-1:0], q_valid};
            f_vld_reg   <= vld_reg[LOOP];
            m_valid_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= LOOP; j++)
                st_reg[j] <= st_next[j];
            f_sel_reg  <= st_reg[LOOP].sel;
            f_prod_reg <= cfg.second * st_reg[LOOP].y;
            f_q_reg    <= st_reg[LOOP].neg ? -$signed({1'b0, st_reg[LOOP].quo})
                                           : $signed({1'b0, st_reg[LOOP].quo});
        end
    end

    logic signed [57:0] rnd;
    logic signed [29:0] sum;
    logic signed [23:0] sat;

    assign rnd = (f_prod_reg + 58'sd536870912) >>> 30;

    always_comb begin
        unique case (f_sel_reg)
            SEL_BASE:   sum = 30'(cfg.base);
            SEL_SECOND: sum = 30'(cfg.second);
            SEL_RAMP:   sum = 30'(cfg.base) + 30'(f_q_reg);
            SEL_SINE:   sum = 30'(cfg.base) + rnd[29:0];
            default:    sum = 30'(cfg.base);
        endcase
        if (sum > 30'sd8388607)
            sat = 24'sh7FFFFF;
        else if (sum < -30'sd8388608)
            sat = 24'sh800000;
        else
            sat = sum[23:0];
    end

    always_ff @(posedge aclk) begin
        if (en)
            m_setpoint_reg <= sat;
    end

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (vld_reg == $past(vld_reg) && f_vld_reg == $past(f_vld_reg)))
        else $error("pipeline moved while stalled");

endmodule

// ===== hw/rtl/setpoint_profile_generator_top.sv =====
// Top level of the setpoint profile generator.
// Depends on spg_pkg, spg_cfg, spg_front and spg_back.
//
// Usage: program the profile through the APB port while idle, then send
// sample times (unsigned Q16.16 seconds) on s_valid/s_ready/s_sample_time.
// Each request yields one setpoint (signed Q4.20, saturated) on
// m_valid/m_ready/m_setpoint, in request order.
// Throughput: one request per cycle while m_ready is high.
// The pipeline depth is set by the 24-step ramp divider or the CORDIC stage
// chain, whichever is longer, followed by the product and output registers.
// A four-entry queue sits between the input and the pipeline; while m_valid
// is high and m_ready low the pipeline holds, the queue fills, and s_ready
// drops once it is full.
// Reset (aresetn low, synchronous) empties the pipeline and queue and loads
// register defaults: constant mode, all values zero, ramp duration 1.0 s.
module setpoint_profile_generator_top import spg_pkg::*; #(
    parameter int SINE_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_sample_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_setpoint
);
    cfg_t cfg;
    logic q_valid, q_pop;
    q_entry_t q_head;

    spg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_time (s_sample_time),
        .q_pop         (q_pop),
        .q_valid       (q_valid),
        .q_head        (q_head)
    );

    spg_back #(.SINE_STAGES(SINE_STAGES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_setpoint (m_setpoint)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for setpoint_profile_generator_top.
// Drives sample-time requests and APB register writes, predicts each setpoint
// in SystemVerilog and compares the results in order. Depends on spg_pkg.
module testbench;
    import spg_pkg::*;

    localparam int  STAGES = 16;
    localparam int  LATENCY = 27;
    localparam longint LIMIT = 2000000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [31:0]       s_sample_time = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [23:0] m_setpoint;

    setpoint_profile_generator_top #(.SINE_STAGES(STAGES)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of the registers
    logic [1:0]         p_kind = KIND_CONST;
    logic signed [23:0] p_base = '0;
    logic signed [23:0] p_second = '0;
    logic [31:0]        p_start = '0;
    logic [31:0]        p_dur = 32'd65536;
    logic [31:0]        p_freq = '0;
    logic [15:0]        p_phase = '0;

    logic [31:0]        pending_times[$];
    logic signed [23:0] expected_setpoints[$];
    int                 mismatches = 0;
    int                 checked = 0;
    longint             cycles = 0;
    bit                 hold_sender = 1'b0;
    bit                 s_taken = 1'b0;
    int                 burst_left = 0;
    int                 gap_left = 0;

    function automatic longint floor_sh(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint sine_q230(logic [31:0] angle);
        logic [31:0] a;
        longint x, y, z, nx;
        a = angle;
        x = 652032874;
        y = 0;
        if (a[31:30] == 2'd1 || a[31:30] == 2'd2) a = 32'h8000_0000 - a;
        z = longint'(signed'(a));
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            if (z >= 0) begin
                nx = x - floor_sh(y, i);
                y = y + floor_sh(x, i);
                z = z - longint'(ATAN_TURNS[i]);
            end else begin
                nx = x + floor_sh(y, i);
                y = y - floor_sh(x, i);
                z = z + longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic logic signed [23:0] setpoint_at(logic [31:0] t);
        logic [31:0] d;
        longint r, b, s2, q;
        logic [63:0] turns;
        logic [31:0] ang;
        d = t - p_start;
        b = p_base;
        s2 = p_second;
        r = b;
        if (p_kind == KIND_STEP) begin
            if (t >= p_start) r = s2;
        end else if (p_kind == KIND_RAMP) begin
            if (t > p_start) begin
                if (p_dur == 0 || d >= p_dur) r = s2;
                else begin
                    q = (longint'({32'd0, d}) * (s2 - b)) / longint'({32'd0, p_dur});
                    r = b + q;
                end
            end
        end else if (p_kind == KIND_SINE) begin
            if (t >= p_start) begin
                turns = {32'd0, p_freq} * {32'd0, d};
                ang = turns[39:8] + {p_phase, 16'd0};
                r = b + ((s2 * sine_q230(ang) + (64'sd1 <<< 29)) >>> 30);
            end
        end
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch: %s got %0h expected %0h", what, got, want);
    endtask

    // APB write, also updates the predictor
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KIND:   p_kind = value[1:0];
            REG_BASE:   p_base = value[23:0];
            REG_SECOND: p_second = value[23:0];
            REG_START:  p_start = value;
            REG_DUR:    p_dur = value;
            REG_FREQ:   p_freq = value;
            REG_PHASE:  p_phase = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain_and_settle();
        while (pending_times.size() != 0 || expected_setpoints.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_profile(logic [1:0] kind, logic [31:0] base, logic [31:0] sec,
                                 logic [31:0] start, logic [31:0] dur,
                                 logic [31:0] freq, logic [31:0] phase);
        write_reg(REG_KIND, {30'd0, kind});
        write_reg(REG_BASE, base);
        write_reg(REG_SECOND, sec);
        write_reg(REG_START, start);
        write_reg(REG_DUR, dur);
        write_reg(REG_FREQ, freq);
        write_reg(REG_PHASE, phase);
    endtask

    function automatic logic [31:0] rand_time(logic [31:0] start, logic [31:0] dur);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return start - $urandom_range(0, 3);
            2: return start + $urandom_range(0, 3);
            3: return start + dur - $urandom_range(0, 2);
            default: return start + ($urandom % (dur == 0 ? 32'd16 : dur + 32'd16));
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            // s_taken: request taken at the last rising edge
            if (!s_valid || s_taken) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_times.size() != 0 && !hold_sender) begin
                    s_valid <= 1'b1;
                    s_sample_time <= pending_times[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            case (cycles % 300 < 100 ? 0 : 1)
                0: m_ready <= 1'b1;
                default: m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // acceptance, prediction and checking at the rising edge
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_setpoints.push_back(setpoint_at(s_sample_time));
                void'(pending_times.pop_front());
            end
            if (m_valid && m_ready) begin
                if (expected_setpoints.size() == 0) begin
                    report_mismatch("unexpected setpoint", 32'(m_setpoint), 32'd0);
                end else begin
                    if (m_setpoint !== expected_setpoints[0])
                        report_mismatch("setpoint", 32'(m_setpoint),
                                        32'(expected_setpoints[0]));
                    void'(expected_setpoints.pop_front());
                    checked++;
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("timeout");
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [31:0] st, du;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: constant zero
        pending_times.push_back(32'd0);
        pending_times.push_back(32'hFFFF_FFFF);
        drain_and_settle();

        // step at extremes
        write_profile(KIND_STEP, 32'h0080_0000, 32'h007F_FFFF, 32'h0001_0000, 32'd1, 0, 0);
        pending_times.push_back(32'h0000_FFFF);
        pending_times.push_back(32'h0001_0000);
        pending_times.push_back(32'hFFFF_FFFF);
        drain_and_settle();

        // ramp: zero duration, past end, interior, hold at start
        write_profile(KIND_RAMP, 32'h0080_0000, 32'h007F_FFFF, 32'd100, 32'd0, 0, 0);
        pending_times.push_back(32'd100);
        pending_times.push_back(32'd101);
        drain_and_settle();
        write_reg(REG_DUR, 32'hFFFF_FFFF);
        pending_times.push_back(32'd100);
        pending_times.push_back(32'd101);
        pending_times.push_back(32'h8000_0000);
        pending_times.push_back(32'hFFFF_FFFF);
        drain_and_settle();

        // sine saturating both ways, extreme phase and frequency
        write_profile(KIND_SINE, 32'h007F_0000, 32'h007F_FFFF, 32'd0, 32'd1,
                      32'hFFFF_FFFF, 32'h0000_FFFF);
        for (int i = 0; i < 8; i++) pending_times.push_back(i * 32'h2000_0001);
        drain_and_settle();
        write_reg(REG_BASE, 32'h0080_0000);
        write_reg(REG_PHASE, 32'h0000_4000);
        write_reg(REG_FREQ, 32'h0100_0000);
        for (int i = 0; i < 6; i++) pending_times.push_back(i * 32'h0000_4000);
        drain_and_settle();
        // out-of-range register index
        write_reg(3'd7, 32'hFFFF_FFFF);

        // random phases
        for (int ph = 0; ph < 22; ph++) begin
            st = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
            case ($urandom_range(0, 3))
                0: du = $urandom_range(0, 4);
                1: du = $urandom;
                default: du = $urandom_range(1, 32'h0004_0000);
            endcase
            write_profile(2'(ph % 4), $urandom, $urandom, st, du,
                          ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0400_0000)),
                          $urandom);
            for (int k = 0; k < 50; k++) pending_times.push_back(rand_time(st, du));
            if (ph == 10) begin
                while (pending_times.size() > 25) @(posedge aclk);
                hold_sender = 1'b1;
                while (expected_setpoints.size() != 0 || s_valid) @(posedge aclk);
                repeat (4) @(posedge aclk);
                hold_sender = 1'b0;
            end
            drain_and_settle();
        end

        $display("covered %0d setpoints over all four profile kinds with random handshakes",
                 checked);
        if (mismatches == 0 && expected_setpoints.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/spg_pkg.sv
hw/rtl/spg_cfg.sv
hw/rtl/spg_queue.sv
hw/rtl/spg_front.sv
hw/rtl/spg_back.sv
hw/rtl/setpoint_profile_generator_top.sv
tb/testbench.sv
